// ===== rtl/core/xjcc_pkg.sv =====
package xjcc_pkg;

   localparam logic [7:0] REP_PREFIX   = 8'hF3;
   localparam logic [7:0] REPNE_PREFIX = 8'hF2;
   localparam logic [7:0] ESCAPE_BYTE  = 8'h0F;
   localparam logic [3:0] SHORT_JCC_HI = 4'h7;
   localparam logic [3:0] NEAR_JCC_HI  = 4'h8;

   localparam logic [3:0] LEN_SHORT_REL8  = 4'd2;
   localparam logic [3:0] LEN_SHORT_REL16 = 4'd3;
   localparam logic [3:0] LEN_NEAR_REL16  = 4'd4;
   localparam logic [3:0] LEN_NEAR_REL32  = 4'd6;

   localparam int CF_BIT = 0;
   localparam int PF_BIT = 2;
   localparam int ZF_BIT = 6;
   localparam int SF_BIT = 7;
   localparam int OF_BIT = 11;

   localparam logic [15:0] MASK_CF = 16'h0001;
   localparam logic [15:0] MASK_PF = 16'h0004;
   localparam logic [15:0] MASK_ZF = 16'h0040;
   localparam logic [15:0] MASK_SF = 16'h0080;
   localparam logic [15:0] MASK_OF = 16'h0800;

   localparam logic [2:0] COND_O  = 3'd0;
   localparam logic [2:0] COND_B  = 3'd1;
   localparam logic [2:0] COND_Z  = 3'd2;
   localparam logic [2:0] COND_BE = 3'd3;
   localparam logic [2:0] COND_S  = 3'd4;
   localparam logic [2:0] COND_P  = 3'd5;
   localparam logic [2:0] COND_L  = 3'd6;
   localparam logic [2:0] COND_LE = 3'd7;

   typedef struct packed {
      logic [7:0]  lead_byte;
      logic [7:0]  second_byte;
      logic [31:0] disp_bytes;
      logic [31:0] insn_address;
      logic [3:0]  insn_length;
      logic [11:0] flags_word;
      logic [15:0] mask_in;
   } req_type;

   typedef struct packed {
      logic        decoded;
      logic        taken;
      logic        target_valid;
      logic [31:0] target_address;
      logic [15:0] mask_out;
   } rsp_type;

endpackage

// ===== rtl/core/xjcc_cond.sv =====
module xjcc_cond
   import xjcc_pkg::*;
(
   input  logic [3:0]  cond_code,
   input  logic [11:0] flags_word,
   output logic        taken,
   output logic [15:0] used_mask
);

   logic cf;
   logic pf;
   logic zf;
   logic sf;
   logic of;
   logic raw;

   assign cf = flags_word[CF_BIT];
   assign pf = flags_word[PF_BIT];
   assign zf = flags_word[ZF_BIT];
   assign sf = flags_word[SF_BIT];
   assign of = flags_word[OF_BIT];

   always_comb begin
      unique case (cond_code[3:1])
         COND_O: begin
            raw       = of;
            used_mask = MASK_OF;
         end
         COND_B: begin
            raw       = cf;
            used_mask = MASK_CF;
         end
         COND_Z: begin
            raw       = zf;
            used_mask = MASK_ZF;
         end
         COND_BE: begin
            raw       = cf | zf;
            used_mask = MASK_CF | MASK_ZF;
         end
         COND_S: begin
            raw       = sf;
            used_mask = MASK_SF;
         end
         COND_P: begin
            raw       = pf;
            used_mask = MASK_PF;
         end
         COND_L: begin
            raw       = sf ^ of;
            used_mask = MASK_SF | MASK_OF;
         end
         COND_LE: begin
            raw       = zf | (sf ^ of);
            used_mask = MASK_ZF | MASK_SF | MASK_OF;
         end
         default: begin
            raw       = 1'b0;
            used_mask = '0;
         end
      endcase
   end

   // odd codes negate the condition
   assign taken = raw ^ cond_code[0];

endmodule

// ===== rtl/core/xjcc_eval.sv =====
module xjcc_eval
   import xjcc_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic        is_rep;
   logic        is_short;
   logic        is_near;
   logic [3:0]  cond_code;
   logic        cond_taken;
   logic [15:0] cond_used;
   logic [31:0] rel;
   logic        rel_valid;
   logic [31:0] jump_target;

   assign is_rep   = (req.lead_byte == REP_PREFIX) || (req.lead_byte == REPNE_PREFIX);
   assign is_short = (req.lead_byte[7:4] == SHORT_JCC_HI);
   assign is_near  = (req.lead_byte == ESCAPE_BYTE) && (req.second_byte[7:4] == NEAR_JCC_HI);

   assign cond_code = is_short ? req.lead_byte[3:0] : req.second_byte[3:0];

   xjcc_cond u_cond (
      .cond_code  (cond_code),
      .flags_word (req.flags_word),
      .taken      (cond_taken),
      .used_mask  (cond_used)
   );

   // displacement select by form and length
   always_comb begin
      rel       = '0;
      rel_valid = 1'b0;
      if (is_short) begin
         rel_valid = 1'b1;
         priority if (req.insn_length == LEN_SHORT_REL8) begin
            rel = {{24{req.second_byte[7]}}, req.second_byte};
         end else if (req.insn_length == LEN_SHORT_REL16) begin
            rel = {{16{req.disp_bytes[7]}}, req.disp_bytes[7:0], req.second_byte};
         end else begin
            rel = '0;
         end
      end else begin
         priority if (req.insn_length == LEN_NEAR_REL16) begin
            rel       = {{16{req.disp_bytes[15]}}, req.disp_bytes[15:0]};
            rel_valid = 1'b1;
         end else if (req.insn_length == LEN_NEAR_REL32) begin
            rel       = req.disp_bytes;
            rel_valid = 1'b1;
         end else begin
            rel       = '0;
            rel_valid = 1'b0;
         end
      end
   end

   assign jump_target = req.insn_address + {28'd0, req.insn_length} + rel;

   always_comb begin
      rsp.decoded        = 1'b0;
      rsp.taken          = 1'b0;
      rsp.target_valid   = 1'b0;
      rsp.target_address = '0;
      rsp.mask_out       = req.mask_in;
      priority if (is_rep) begin
         rsp.decoded        = 1'b1;
         rsp.taken          = (req.lead_byte == REP_PREFIX) ? req.flags_word[ZF_BIT]
                                                            : ~req.flags_word[ZF_BIT];
         rsp.target_valid   = 1'b1;
         rsp.target_address = req.insn_address;
         rsp.mask_out       = req.mask_in | MASK_ZF;
      end else if (is_short || is_near) begin
         rsp.decoded        = 1'b1;
         rsp.taken          = cond_taken;
         rsp.target_valid   = rel_valid;
         rsp.target_address = rel_valid ? jump_target : '0;
         rsp.mask_out       = req.mask_in | cond_used;
      end else begin
         rsp.decoded        = 1'b0;
      end
   end

endmodule

// ===== rtl/core/x86_jcc_condition_and_target.sv =====
// x86 conditional jump condition and target evaluator
//
// req channel: one beat per instruction (lead byte, second byte, four
// displacement bytes, address, length, flags and flag-use mask).
// rsp channel: one beat per request with decoded, taken, target_valid,
// target_address and the updated flag-use mask.
// Both channels are valid/ready; a beat moves when valid and ready are high.
//
// a req beat reaches rsp_valid through the input register, then the result
// register behind the decode and one 32-bit three-input add.
// throughput: one beat per cycle, sustained while rsp_ready stays high.
// when rsp_ready is low the result register holds its beat and the input
// register still takes one more request; after that req_ready drops until
// the result is taken.
// reset (synchronous, active high) empties both registers; no beat is
// presented and req_ready is high once reset is released.
module x86_jcc_condition_and_target
   import xjcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type eval_rsp;
   logic    out_ready;

   assign out_ready   = ~out_valid_ff | rsp_ready;
   assign req_ready   = ~in_valid_ff | out_ready;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   xjcc_eval u_eval (
      .req (in_data_ff),
      .rsp (eval_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (in_valid_ff && out_ready) begin
         out_data_ff <= eval_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_empty_input_takes_beat: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but req_ready low");

   a_undecoded_is_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.decoded |->
         !rsp_data.taken && !rsp_data.target_valid && (rsp_data.target_address == 32'd0))
      else $error("undecoded beat carries a branch result");

   a_no_target_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.target_valid |-> rsp_data.target_address == 32'd0)
      else $error("target address nonzero without target_valid");

   a_mask_keeps_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_ready |=>
         rsp_valid && ((rsp_data.mask_out & $past(in_data_ff.mask_in))
                       == $past(in_data_ff.mask_in)))
      else $error("mask_out dropped bits of mask_in");

   a_rep_targets_self: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_ready && ((in_data_ff.lead_byte == REP_PREFIX) ||
                                   (in_data_ff.lead_byte == REPNE_PREFIX)) |=>
         rsp_data.decoded && (rsp_data.target_address == $past(in_data_ff.insn_address)))
      else $error("repeat prefix target is not the instruction address");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import xjcc_pkg::*;

   localparam int RANDOM_BEATS = 1926;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   localparam int RX_OPEN   = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_STALLS = 2;
   localparam int RX_SLOW   = 3;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } jcc_vector_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type        branch_q[$];
   jcc_vector_type jcc_vectors[$];
   int             fail_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             rx_mode = RX_OPEN;
   int             rx_mode_left = 0;
   int             rx_hold_left = 0;

   x86_jcc_condition_and_target uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic cond_taken(input logic [3:0] cc, input logic [11:0] fl,
                                       output logic [15:0] used);
      logic cf, pf, zf, sf, ovf, r;
      cf  = fl[CF_BIT];
      pf  = fl[PF_BIT];
      zf  = fl[ZF_BIT];
      sf  = fl[SF_BIT];
      ovf = fl[OF_BIT];
      case (cc[3:1])
         COND_O: begin
            r = ovf;
            used = MASK_OF;
         end
         COND_B: begin
            r = cf;
            used = MASK_CF;
         end
         COND_Z: begin
            r = zf;
            used = MASK_ZF;
         end
         COND_BE: begin
            r = cf | zf;
            used = MASK_CF | MASK_ZF;
         end
         COND_S: begin
            r = sf;
            used = MASK_SF;
         end
         COND_P: begin
            r = pf;
            used = MASK_PF;
         end
         COND_L: begin
            r = sf ^ ovf;
            used = MASK_SF | MASK_OF;
         end
         default: begin
            r = zf | (sf ^ ovf);
            used = MASK_ZF | MASK_SF | MASK_OF;
         end
      endcase
      return r ^ cc[0];
   endfunction

   function automatic rsp_type jcc_predict(req_type r);
      rsp_type     p;
      logic [15:0] used;
      logic [31:0] rel;
      logic [31:0] next_pc;
      p = '0;
      used = '0;
      rel = '0;
      next_pc = r.insn_address + {28'd0, r.insn_length};
      if (r.lead_byte == REP_PREFIX || r.lead_byte == REPNE_PREFIX) begin
         p.decoded = 1'b1;
         p.taken = (r.lead_byte == REP_PREFIX) ? r.flags_word[ZF_BIT] : !r.flags_word[ZF_BIT];
         p.target_valid = 1'b1;
         p.target_address = r.insn_address;
         used = MASK_ZF;
      end else if (r.lead_byte[7:4] == SHORT_JCC_HI) begin
         p.decoded = 1'b1;
         p.taken = cond_taken(r.lead_byte[3:0], r.flags_word, used);
         if (r.insn_length == LEN_SHORT_REL8) begin
            rel = {{24{r.second_byte[7]}}, r.second_byte};
         end else if (r.insn_length == LEN_SHORT_REL16) begin
            rel = {{16{r.disp_bytes[7]}}, r.disp_bytes[7:0], r.second_byte};
         end
         p.target_valid = 1'b1;
         p.target_address = next_pc + rel;
      end else if (r.lead_byte == ESCAPE_BYTE && r.second_byte[7:4] == NEAR_JCC_HI) begin
         p.decoded = 1'b1;
         p.taken = cond_taken(r.second_byte[3:0], r.flags_word, used);
         if (r.insn_length == LEN_NEAR_REL16) begin
            p.target_valid = 1'b1;
            p.target_address = next_pc + {{16{r.disp_bytes[15]}}, r.disp_bytes[15:0]};
         end else if (r.insn_length == LEN_NEAR_REL32) begin
            p.target_valid = 1'b1;
            p.target_address = next_pc + r.disp_bytes;
         end
      end
      p.mask_out = r.mask_in | used;
      return p;
   endfunction

   function automatic req_type mk_req(logic [7:0] lead, logic [7:0] sec, logic [31:0] disp,
                                      logic [31:0] addr, logic [3:0] len,
                                      logic [11:0] fl, logic [15:0] mask);
      req_type r;
      r.lead_byte = lead;
      r.second_byte = sec;
      r.disp_bytes = disp;
      r.insn_address = addr;
      r.insn_length = len;
      r.flags_word = fl;
      r.mask_in = mask;
      return r;
   endfunction

   task automatic add_vector(req_type r, bit fixed, rsp_type rsp);
      jcc_vector_type v;
      v.req = r;
      v.fixed = fixed;
      v.rsp = rsp;
      jcc_vectors.push_back(v);
   endtask

   function automatic logic [3:0] pick_length(logic [3:0] a, logic [3:0] b);
      if ($urandom_range(0, 3) == 0) begin
         return 4'($urandom_range(1, 15));
      end
      return $urandom_range(0, 1) ? a : b;
   endfunction

   function automatic req_type random_insn();
      req_type r;
      int      pick;
      r.second_byte = 8'($urandom);
      r.disp_bytes = $urandom;
      r.insn_address = $urandom;
      r.flags_word = 12'($urandom);
      r.mask_in = 16'($urandom);
      r.insn_length = 4'($urandom_range(1, 15));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         r.lead_byte = {SHORT_JCC_HI, 4'($urandom)};
         r.insn_length = pick_length(LEN_SHORT_REL8, LEN_SHORT_REL16);
      end else if (pick < 70) begin
         r.lead_byte = ESCAPE_BYTE;
         r.second_byte = {NEAR_JCC_HI, 4'($urandom)};
         r.insn_length = pick_length(LEN_NEAR_REL16, LEN_NEAR_REL32);
      end else if (pick < 85) begin
         r.lead_byte = $urandom_range(0, 1) ? REP_PREFIX : REPNE_PREFIX;
      end else if (pick < 92) begin
         r.lead_byte = ESCAPE_BYTE;
      end else begin
         r.lead_byte = 8'($urandom);
      end
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_beat(req_type r, bit fixed, rsp_type rsp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      branch_q.push_back(fixed ? rsp : jcc_predict(r));
      @(negedge clock);
   endtask

   task automatic wait_all_retired();
      req_valid <= 1'b0;
      do @(negedge clock); while (branch_q.size() != 0);
   endtask

   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = $urandom_range(RX_OPEN, RX_SLOW);
         rx_mode_left = $urandom_range(20, 150);
      end
      rx_mode_left--;
      case (rx_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         RX_STALLS: begin
            if (rx_hold_left > 0) begin
               rx_hold_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) rx_hold_left = $urandom_range(1, 12);
            end
         end
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (branch_q.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = branch_q.pop_front();
            if (rsp_data.decoded !== want.decoded) begin
               $display("%0t: decoded expected %0h actual %0h",
                        $time, want.decoded, rsp_data.decoded);
               fail_count++;
            end
            if (rsp_data.taken !== want.taken) begin
               $display("%0t: taken expected %0h actual %0h", $time, want.taken, rsp_data.taken);
               fail_count++;
            end
            if (rsp_data.target_valid !== want.target_valid) begin
               $display("%0t: target_valid expected %0h actual %0h",
                        $time, want.target_valid, rsp_data.target_valid);
               fail_count++;
            end
            if (rsp_data.target_address !== want.target_address) begin
               $display("%0t: target_address expected %h actual %h",
                        $time, want.target_address, rsp_data.target_address);
               fail_count++;
            end
            if (rsp_data.mask_out !== want.mask_out) begin
               $display("%0t: mask_out expected %h actual %h",
                        $time, want.mask_out, rsp_data.mask_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("x86_jcc_condition_and_target: mismatch");
         $finish;
      end
   end

   initial begin
      // unknown opcodes pass the mask through
      add_vector(mk_req(8'h00, 8'h00, 32'h0, 32'h0, 4'd1, 12'h000, 16'h0000), 1,
                 '{1'b0, 1'b0, 1'b0, 32'h0, 16'h0000});
      add_vector(mk_req(8'hFF, 8'hFF, '1, '1, 4'd15, 12'hFFF, 16'hFFFF), 1,
                 '{1'b0, 1'b0, 1'b0, 32'h0, 16'hFFFF});
      add_vector(mk_req(ESCAPE_BYTE, 8'h7F, '1, 32'h1000, 4'd6, 12'hFFF, 16'h1234), 1,
                 '{1'b0, 1'b0, 1'b0, 32'h0, 16'h1234});
      add_vector(mk_req(ESCAPE_BYTE, 8'h90, 32'h0, 32'h2000, 4'd4, 12'h000, 16'h0000), 1,
                 '{1'b0, 1'b0, 1'b0, 32'h0, 16'h0000});
      add_vector(mk_req(8'h6F, 8'h10, 32'h0, 32'h3000, 4'd2, 12'hFFF, 16'h8001), 1,
                 '{1'b0, 1'b0, 1'b0, 32'h0, 16'h8001});
      add_vector(mk_req(8'h80, 8'h10, 32'h0, 32'h3000, 4'd2, 12'hFFF, 16'h0800), 1,
                 '{1'b0, 1'b0, 1'b0, 32'h0, 16'h0800});
      // repeat prefixes branch back to themselves
      add_vector(mk_req(REP_PREFIX, 8'h00, 32'h0, 32'h0040_1000, 4'd2, 12'h040, 16'h0000), 1,
                 '{1'b1, 1'b1, 1'b1, 32'h0040_1000, 16'h0040});
      add_vector(mk_req(REP_PREFIX, 8'hA5, '1, 32'h0, 4'd1, 12'hFBF, 16'h0001), 1,
                 '{1'b1, 1'b0, 1'b1, 32'h0, 16'h0041});
      add_vector(mk_req(REPNE_PREFIX, 8'h00, 32'h0, 32'h8000_0000, 4'd3, 12'h000, 16'h0000),
                 1, '{1'b1, 1'b1, 1'b1, 32'h8000_0000, 16'h0040});
      add_vector(mk_req(REPNE_PREFIX, 8'hFF, '1, '1, 4'd15, 12'hFFF, 16'hFFFF), 1,
                 '{1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF});
      // short jumps: rel8, rel16, no displacement, wrap
      add_vector(mk_req(8'h70, 8'h80, 32'h0, 32'h0, LEN_SHORT_REL8, 12'h800, 16'h0), 0, '0);
      add_vector(mk_req(8'h7F, 8'h7F, 32'h0, '1, LEN_SHORT_REL8, 12'h000, 16'h0), 0, '0);
      add_vector(mk_req(8'h74, 8'h00, 32'hFFFF_FF80, 32'h10, LEN_SHORT_REL16, 12'h040, 16'h0),
                 0, '0);
      add_vector(mk_req(8'h75, 8'hFF, 32'h0000_007F, '1, LEN_SHORT_REL16, 12'hFBF, 16'h0),
                 0, '0);
      add_vector(mk_req(8'h7A, 8'h33, '1, 32'h5000, 4'd5, 12'h004, 16'h0), 0, '0);
      add_vector(mk_req(8'h7B, 8'h33, '1, 32'h5000, 4'd1, 12'h004, 16'h0), 0, '0);
      add_vector(mk_req(8'h7C, 8'h10, 32'h0, 32'h6000, LEN_SHORT_REL8, 12'h800, 16'h0), 0, '0);
      add_vector(mk_req(8'h7E, 8'hF0, 32'h0, 32'h6000, LEN_SHORT_REL8, 12'h880, 16'h0), 0, '0);
      add_vector(mk_req(8'h72, 8'h01, 32'h0, 32'h7000, LEN_SHORT_REL8, 12'h001, 16'h0), 0, '0);
      // near jumps: rel16, rel32, unsupported length
      add_vector(mk_req(ESCAPE_BYTE, 8'h80, 32'h0000_8000, 32'h0, LEN_NEAR_REL16, 12'h800,
                        16'h0), 0, '0);
      add_vector(mk_req(ESCAPE_BYTE, 8'h8F, '1, 32'h0, LEN_NEAR_REL32, 12'h000, 16'h0), 0, '0);
      add_vector(mk_req(ESCAPE_BYTE, 8'h8A, 32'h8000_0000, '1, LEN_NEAR_REL32, 12'h004,
                        16'h0), 0, '0);
      add_vector(mk_req(ESCAPE_BYTE, 8'h84, '1, 32'h9000, 4'd5, 12'h040, 16'h0), 0, '0);
      add_vector(mk_req(ESCAPE_BYTE, 8'h85, '1, 32'h9000, 4'd15, 12'h040, 16'hFFFF), 0, '0);
      add_vector(mk_req(ESCAPE_BYTE, 8'h8E, 32'h0000_7FFF, 32'hFFFF_0000, LEN_NEAR_REL16,
                        12'h840, 16'h0), 0, '0);

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      foreach (jcc_vectors[i]) begin
         send_beat(jcc_vectors[i].req, jcc_vectors[i].fixed, jcc_vectors[i].rsp);
      end
      wait_all_retired();
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == RANDOM_BEATS / 2) wait_all_retired();
         send_beat(random_insn(), 0, '0);
      end
      req_valid <= 1'b0;
      while (branch_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("x86_jcc_condition_and_target: match");
      end else begin
         $display("x86_jcc_condition_and_target: mismatch");
      end
      $finish;
   end

endmodule
